// ===== sv/float_to_pcm_convert_core_macros.svh =====
// assertion macros for the float to pcm converter
`ifndef FLOAT_TO_PCM_CONVERT_CORE_MACROS_SVH
`define FLOAT_TO_PCM_CONVERT_CORE_MACROS_SVH

// checked while out of reset
`define F2PCM_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("f2pcm assertion failed");

// checked on the next cycle, reset included
`define F2PCM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("f2pcm assertion failed");

`endif

// ===== sv/f2pcm_pkg.sv =====
`default_nettype none

package f2pcm_pkg;

    localparam int NUM_STAGES = 5;

    typedef enum logic [1:0] {
        W16   = 2'd0,
        W24   = 2'd1,
        W32   = 2'd2,
        WNONE = 2'd3
    } t_width;

    localparam logic [22:0] K16 = 23'd32767;
    localparam logic [22:0] K24 = 23'd8388607;
    localparam logic [22:0] K32 = 23'd1;

    localparam logic [7:0]  EXP_ONE  = 8'd127;
    localparam logic [7:0]  EXP_MAX  = 8'd255;
    localparam logic [9:0]  EXP_BIAS = 10'd150;
    localparam logic [31:0] POS_MAX  = 32'h7fff_ffff;

    typedef struct packed {
        logic [31:0] sample_float;
        logic        last_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pcm_value;
        logic               last_out;
    } t_out_item;

endpackage

`default_nettype wire

// ===== sv/float_to_pcm_convert_core.sv =====
// channel   direction  handshake                    payload
// cfg       in         i_cfg_wr_en                  i_cfg_wr_data (width code)
// in        in         i_in_valid / o_in_ready      i_in_data (t_in_item)
// out       out        o_out_valid / i_out_ready    o_out_data (t_out_item)
//
// five register stages: clamp, multiply, float round, shift, integer round
// one item per cycle while the output is not stalled
// a stall at the output holds each full stage whose later stages are all full; empty stages still fill
// synchronous active low reset clears the valid bits and sets the width code to 16 bits
`default_nettype none

module float_to_pcm_convert_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [1:0]           i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  f2pcm_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output f2pcm_pkg::t_out_item o_out_data
);
    import f2pcm_pkg::*;

    t_width                r_cfg;
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES:0]   w_rdy;

    // stage 1
    logic        r_s1_sign, n_s1_sign;
    logic [23:0] r_s1_man, n_s1_man;
    logic [7:0]  r_s1_exp, n_s1_exp;
    logic        r_s1_zero, n_s1_zero;
    t_width      r_s1_wc;
    logic        r_s1_last;
    // stage 2
    logic        r_s2_sign, r_s2_zero, r_s2_last;
    logic [7:0]  r_s2_exp;
    t_width      r_s2_wc;
    logic [46:0] r_s2_prod, n_s2_prod;
    logic [22:0] w_k;
    // stage 3
    logic        r_s3_sign, r_s3_null, r_s3_last;
    logic [24:0] r_s3_sig, n_s3_sig;
    logic signed [9:0] r_s3_exp, n_s3_exp;
    logic [23:0] w_kept;
    logic        w_g3, w_st3;
    logic [5:0]  w_adj;
    // stage 4
    logic        r_s4_sign, r_s4_null, r_s4_last;
    logic [31:0] r_s4_q, n_s4_q;
    logic        r_s4_inc, n_s4_inc;
    logic [9:0]  w_sh;
    logic [56:0] w_ext;
    // stage 5
    t_out_item   r_s5, n_s5;
    logic [32:0] w_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= W16;
        end else if (i_cfg_wr_en) begin
            r_cfg <= t_width'(i_cfg_wr_data);
        end
    end

    always_comb begin
        w_rdy[NUM_STAGES] = i_out_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--) begin
            w_rdy[i] = !r_vld[i] || w_rdy[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (w_rdy[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // clamp
    always_comb begin
        logic [7:0]  e;
        logic [22:0] f;
        e = i_in_data.sample_float[30:23];
        f = i_in_data.sample_float[22:0];
        n_s1_sign = i_in_data.sample_float[31];
        n_s1_man  = {1'b1, f};
        n_s1_exp  = e;
        n_s1_zero = (e == 8'd0);
        if (e == EXP_MAX && f != 23'd0) begin
            n_s1_sign = 1'b0;
            n_s1_man  = 24'h80_0000;
            n_s1_exp  = EXP_ONE;
        end else if (e > EXP_ONE || (e == EXP_ONE && f != 23'd0)) begin
            n_s1_man  = 24'h80_0000;
            n_s1_exp  = EXP_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s1_sign <= n_s1_sign;
            r_s1_man  <= n_s1_man;
            r_s1_exp  <= n_s1_exp;
            r_s1_zero <= n_s1_zero;
            r_s1_wc   <= r_cfg;
            r_s1_last <= i_in_data.last_sample;
        end
    end

    // multiply by full scale
    always_comb begin
        unique case (r_s1_wc)
            W16:     w_k = K16;
            W24:     w_k = K24;
            default: w_k = K32;
        endcase
        n_s2_prod = 47'(r_s1_man) * 47'(w_k);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s2_prod <= n_s2_prod;
            r_s2_sign <= r_s1_sign;
            r_s2_exp  <= r_s1_exp;
            r_s2_zero <= r_s1_zero;
            r_s2_wc   <= r_s1_wc;
            r_s2_last <= r_s1_last;
        end
    end

    // round product to 24 significant bits
    always_comb begin
        unique case (r_s2_wc)
            W16: begin
                if (r_s2_prod[38]) begin
                    w_kept = r_s2_prod[38:15];
                    w_g3   = r_s2_prod[14];
                    w_st3  = |r_s2_prod[13:0];
                    w_adj  = 6'd15;
                end else begin
                    w_kept = r_s2_prod[37:14];
                    w_g3   = r_s2_prod[13];
                    w_st3  = |r_s2_prod[12:0];
                    w_adj  = 6'd14;
                end
            end
            W24: begin
                if (r_s2_prod[46]) begin
                    w_kept = r_s2_prod[46:23];
                    w_g3   = r_s2_prod[22];
                    w_st3  = |r_s2_prod[21:0];
                    w_adj  = 6'd23;
                end else begin
                    w_kept = r_s2_prod[45:22];
                    w_g3   = r_s2_prod[21];
                    w_st3  = |r_s2_prod[20:0];
                    w_adj  = 6'd22;
                end
            end
            default: begin
                w_kept = r_s2_prod[23:0];
                w_g3   = 1'b0;
                w_st3  = 1'b0;
                w_adj  = 6'd31;
            end
        endcase
        n_s3_sig = {1'b0, w_kept} + 25'(w_g3 && (w_st3 || w_kept[0]));
        n_s3_exp = $signed({2'b00, r_s2_exp}) + $signed({4'b0000, w_adj})
                   - $signed(EXP_BIAS);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_s3_sig  <= n_s3_sig;
            r_s3_exp  <= n_s3_exp;
            r_s3_sign <= r_s2_sign;
            r_s3_null <= r_s2_zero || (r_s2_wc == WNONE);
            r_s3_last <= r_s2_last;
        end
    end

    // align to integer
    always_comb begin
        w_sh  = 10'(-r_s3_exp);
        w_ext = {r_s3_sig, 32'd0} >> w_sh[4:0];
        if (!r_s3_exp[9]) begin
            n_s4_q   = 32'(r_s3_sig) << r_s3_exp[3:0];
            n_s4_inc = 1'b0;
        end else if (w_sh > 10'd31) begin
            n_s4_q   = 32'd0;
            n_s4_inc = 1'b0;
        end else begin
            n_s4_q   = {7'd0, w_ext[56:32]};
            n_s4_inc = w_ext[31] && ((|w_ext[30:0]) || w_ext[32]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_s4_q    <= n_s4_q;
            r_s4_inc  <= n_s4_inc;
            r_s4_sign <= r_s3_sign;
            r_s4_null <= r_s3_null;
            r_s4_last <= r_s3_last;
        end
    end

    // round half to even, sign, saturate positive values; null items give zero
    always_comb begin
        w_mag = {1'b0, r_s4_q} + 33'(r_s4_inc);
        n_s5.last_out = r_s4_last;
        if (r_s4_null) begin
            n_s5.pcm_value = '0;
        end else if (!r_s4_sign) begin
            n_s5.pcm_value = (w_mag[32:31] != 2'b00) ? POS_MAX : w_mag[31:0];
        end else begin
            n_s5.pcm_value = -w_mag[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_s5 <= n_s5;
        end
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];
    assign o_out_data  = r_s5;

endmodule

`default_nettype wire

// ===== sv/f2pcm_checker.sv =====
`default_nettype none

module f2pcm_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_wr_en,
    input logic [1:0]           i_cfg_wr_data,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input f2pcm_pkg::t_in_item  i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input f2pcm_pkg::t_out_item o_out_data
);
    import f2pcm_pkg::*;
`include "float_to_pcm_convert_core_macros.svh"

    // a taken output frees the whole chain
    `F2PCM_ASSERT(a_ready_follows, i_out_ready, o_in_ready)
    // held result stays put
    `F2PCM_ASSERT_NEXT(a_out_hold, i_rst_n && o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    // reset empties the pipeline
    `F2PCM_ASSERT_NEXT(a_reset_empty, !i_rst_n, !o_out_valid)

endmodule

bind float_to_pcm_convert_core f2pcm_checker u_f2pcm_checker (.*);

`default_nettype wire
